>>> hw/rtl/rla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rla_pkg: shared types and constants of the rectangle layer assigner
// Edge record kept per stored rectangle, field widths, default sizes.
// ----------------------------------------------------------------------------
package rla_pkg;

    localparam int CENTER_W        = 16;
    localparam int SIZE_W          = 15;
    localparam int OUT_IDX_W       = 4;
    // doubled units: 2*center +- size fits in 18 signed bits
    localparam int EDGE_W          = 18;
    localparam int DEF_MAX_LAYERS  = 16;
    localparam int DEF_MAX_COLUMNS = 16;

    typedef struct packed {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
        logic signed [EDGE_W-1:0] top;
    } edges_t;

    localparam int EDGES_BITS = $bits(edges_t);

endpackage
`default_nettype wire

>>> hw/rtl/rla_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rla_if: valid/ready channels of the rectangle layer assigner
// Input channel carries one rectangle per word, output channel one placement.
// ----------------------------------------------------------------------------
interface rect_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic        [14:0] box_width;
    logic        [14:0] box_height;

    modport source (output valid, center_x, center_y, box_width, box_height,
                    input ready);
    modport sink   (input valid, center_x, center_y, box_width, box_height,
                    output ready);
endinterface

interface rect_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] layer_index;
    logic [3:0] column_index;
    logic       overflow;

    modport source (output valid, layer_index, column_index, overflow, input ready);
    modport sink   (input valid, layer_index, column_index, overflow, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rect_layer_assigner_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rect_layer_assigner_unit: greedy layer assignment of rectangles
// Places each rectangle in the first layer free of corner conflicts, or flags overflow.
// ----------------------------------------------------------------------------
// One rectangle word is taken at a time. Its doubled edges are formed on
// accept, then each open layer is scanned from layer 0: the fill count is
// read from the fill RAM (states FILL_RD and FILL_WT), then the layer's
// stored rectangles are streamed from the rectangle RAM, one per cycle, and
// tested against the new box; a conflict moves on to the next layer at once.
// Around the scans come the idle, place (or open, then place) and result
// states; the scan speed is set by the single read port of the rectangle
// RAM. The result goes to an output register, and the next rectangle is
// taken once that register has accepted it. Stores need no clearing pass:
// a layer's fill entry is written when the layer is opened, and only
// entries below the fill are read.
// ----------------------------------------------------------------------------
module rect_layer_assigner_unit
    import rla_pkg::*;
#(
    parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rect_in_if.sink     rect_in,
    rect_out_if.source  result
);

    localparam int LAYER_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int CNT_W   = $clog2(MAX_LAYERS + 1);
    localparam int FILL_W  = $clog2(MAX_COLUMNS + 1);
    localparam int DEPTH   = MAX_LAYERS * MAX_COLUMNS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        IDLE,
        FILL_RD,
        FILL_WT,
        SCAN,
        OPEN,
        PLACE,
        RESULT
    } state_t;

    state_t              state_reg,       state_next;
    edges_t              box_reg,         box_next;
    logic [LAYER_W-1:0]  layer_reg,       layer_next;
    logic [CNT_W-1:0]    used_reg,        used_next;
    logic [FILL_W-1:0]   n_reg,           n_next;
    logic [FILL_W-1:0]   iss_reg,         iss_next;
    logic [FILL_W-1:0]   chk_reg,         chk_next;
    logic                rv_reg,          rv_next;
    logic [OUT_IDX_W-1:0] res_layer_reg,  res_layer_next;
    logic [OUT_IDX_W-1:0] res_col_reg,    res_col_next;
    logic                res_ovf_reg,     res_ovf_next;
    logic                out_valid_reg,   out_valid_next;
    logic [OUT_IDX_W-1:0] out_layer_reg,  out_layer_next;
    logic [OUT_IDX_W-1:0] out_col_reg,    out_col_next;
    logic                out_ovf_reg,     out_ovf_next;

    logic                store_we;
    logic [ADDR_W-1:0]   store_waddr;
    logic [ADDR_W-1:0]   store_raddr;
    logic [EDGES_BITS-1:0] store_rdata;
    logic                fill_we;
    logic [FILL_W-1:0]   fill_wdata;
    logic [FILL_W-1:0]   fill_rdata;
    logic                hit;
    logic                in_fire;
    logic                room;
    edges_t              new_box;
    logic [ADDR_W-1:0]   row_base;

    assign in_fire = rect_in.valid && rect_in.ready;
    assign room    = (n_reg < FILL_W'(MAX_COLUMNS));

    // doubled edges of the incoming word
    always_comb
    begin
        logic signed [EDGE_W-1:0] cx2, cy2, w, h;
        cx2 = EDGE_W'(rect_in.center_x) <<< 1;
        cy2 = EDGE_W'(rect_in.center_y) <<< 1;
        w   = EDGE_W'(rect_in.box_width);
        h   = EDGE_W'(rect_in.box_height);
        new_box.left   = cx2 - w;
        new_box.right  = cx2 + w;
        new_box.bottom = cy2 - h;
        new_box.top    = cy2 + h;
    end

    assign row_base    = ADDR_W'(layer_reg) * ADDR_W'(MAX_COLUMNS);
    assign store_raddr = row_base + ADDR_W'(iss_reg);
    assign store_waddr = row_base + ADDR_W'(n_reg);
    assign store_we    = (state_reg == PLACE) && room;
    assign fill_we     = store_we;
    assign fill_wdata  = n_reg + FILL_W'(1);

    rla_ram #(.WIDTH(EDGES_BITS), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (box_reg),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    rla_ram #(.WIDTH(FILL_W), .DEPTH(MAX_LAYERS)) u_fill (
        .clk   (clk),
        .we    (fill_we),
        .waddr (layer_reg),
        .wdata (fill_wdata),
        .raddr (layer_reg),
        .rdata (fill_rdata)
    );

    rla_conflict u_conflict (
        .a   (box_reg),
        .b   (edges_t'(store_rdata)),
        .hit (hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        box_next       = box_reg;
        layer_next     = layer_reg;
        used_next      = used_reg;
        n_next         = n_reg;
        iss_next       = iss_reg;
        chk_next       = chk_reg;
        rv_next        = 1'b0;
        res_layer_next = res_layer_reg;
        res_col_next   = res_col_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_layer_next = out_layer_reg;
        out_col_next   = out_col_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            IDLE:
            begin
                if (in_fire)
                begin
                    box_next   = new_box;
                    layer_next = '0;
                    state_next = (used_reg == '0) ? OPEN : FILL_RD;
                end
            end
            FILL_RD:
            begin
                state_next = FILL_WT;
            end
            FILL_WT:
            begin
                n_next     = fill_rdata;
                iss_next   = '0;
                chk_next   = '0;
                state_next = (fill_rdata == '0) ? PLACE : SCAN;
            end
            SCAN:
            begin
                if (rv_reg && hit)
                begin
                    // conflict: drop outstanding read, try next layer or open a new one
                    if (CNT_W'(layer_reg) + CNT_W'(1) == used_reg)
                    begin
                        state_next = OPEN;
                    end
                    else
                    begin
                        layer_next = layer_reg + LAYER_W'(1);
                        state_next = FILL_RD;
                    end
                end
                else if (rv_reg && (chk_reg + FILL_W'(1) == n_reg))
                begin
                    state_next = PLACE;
                end
                else
                begin
                    if (rv_reg)
                    begin
                        chk_next = chk_reg + FILL_W'(1);
                    end
                    if (iss_reg < n_reg)
                    begin
                        iss_next = iss_reg + FILL_W'(1);
                        rv_next  = 1'b1;
                    end
                end
            end
            OPEN:
            begin
                if (used_reg < CNT_W'(MAX_LAYERS))
                begin
                    layer_next = LAYER_W'(used_reg);
                    used_next  = used_reg + CNT_W'(1);
                    n_next     = '0;
                    state_next = PLACE;
                end
                else
                begin
                    res_layer_next = '0;
                    res_col_next   = '0;
                    res_ovf_next   = 1'b1;
                    state_next     = RESULT;
                end
            end
            PLACE:
            begin
                if (room)
                begin
                    res_layer_next = OUT_IDX_W'(layer_reg);
                    res_col_next   = OUT_IDX_W'(n_reg);
                    res_ovf_next   = 1'b0;
                end
                else
                begin
                    res_layer_next = '0;
                    res_col_next   = '0;
                    res_ovf_next   = 1'b1;
                end
                state_next = RESULT;
            end
            RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_layer_next = res_layer_reg;
                    out_col_next   = res_col_reg;
                    out_ovf_next   = res_ovf_reg;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            used_reg      <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_reg       <= box_next;
        layer_reg     <= layer_next;
        n_reg         <= n_next;
        iss_reg       <= iss_next;
        chk_reg       <= chk_next;
        res_layer_reg <= res_layer_next;
        res_col_reg   <= res_col_next;
        res_ovf_reg   <= res_ovf_next;
        out_layer_reg <= out_layer_next;
        out_col_reg   <= out_col_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign rect_in.ready       = (state_reg == IDLE);
    assign result.valid        = out_valid_reg;
    assign result.layer_index  = out_layer_reg;
    assign result.column_index = out_col_reg;
    assign result.overflow     = out_ovf_reg;

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_LAYERS))
        else $error("open layer count beyond limit");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !rect_in.ready)
        else $error("second word taken while busy");

    a_write_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> (CNT_W'(layer_reg) < used_reg))
        else $error("store write to a layer that is not open");

    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.overflow) |->
        (result.layer_index == '0 && result.column_index == '0))
        else $error("overflow result with nonzero indices");

endmodule
`default_nettype wire

>>> hw/rtl/rla_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rla_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/rla_conflict.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rla_conflict: corner containment test between two rectangles
// Hit when any corner of either box lies in the other's closed box.
// ----------------------------------------------------------------------------
module rla_conflict
    import rla_pkg::*;
(
    input  wire edges_t a,
    input  wire edges_t b,
    output logic        hit
);

    function automatic logic inside_box(logic signed [EDGE_W-1:0] px,
                                        logic signed [EDGE_W-1:0] py,
                                        edges_t bx);
        return (px >= bx.left) && (px <= bx.right) &&
               (py >= bx.bottom) && (py <= bx.top);
    endfunction

    function automatic logic corners_in(edges_t p, edges_t q);
        return inside_box(p.left,  p.top,    q) || inside_box(p.right, p.top,    q) ||
               inside_box(p.right, p.bottom, q) || inside_box(p.left,  p.bottom, q);
    endfunction

    assign hit = corners_in(a, b) || corners_in(b, a);

endmodule
`default_nettype wire

>>> sim/tb_rect_layer_assigner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_layer_assigner_unit: self-checking bench of the layer assigner
// A directed set of rectangles covers the field extremes, degenerate boxes,
// shared edges and crossing boxes. Random words follow: clusters, repeats,
// crosses and scattered boxes. Both channels idle at random, with two long
// receiver hold-offs. A layer/column tracker predicts every placement.
// ----------------------------------------------------------------------------
module tb_rect_layer_assigner_unit;
    import rla_pkg::*;

    localparam int RANDOM_ITEMS = 640;
    localparam int LONG_HOLD    = 500;
    localparam int DRAIN_CYCLES = 320;
    localparam int MAX_REPORTS  = 100;

    typedef struct {
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic        [SIZE_W-1:0]   w;
        logic        [SIZE_W-1:0]   h;
    } rect_t;

    typedef struct {
        logic [OUT_IDX_W-1:0] layer;
        logic [OUT_IDX_W-1:0] column;
        logic                 overflow;
    } place_t;

    // Greedy placement tracker: keeps its own copy of the layer store
    class layer_tracker;
        edges_t      stored [DEF_MAX_LAYERS][DEF_MAX_COLUMNS];
        int unsigned fill [DEF_MAX_LAYERS];
        int unsigned open_layers = 0;
        place_t      pending_places [$];
        int          errors     = 0;
        int          n_placed   = 0;
        int          n_overflow = 0;
        int          n_checked  = 0;

        function bit holds(edges_t b, logic signed [EDGE_W-1:0] px,
                           logic signed [EDGE_W-1:0] py);
            return $signed(px) >= $signed(b.left) && $signed(px) <= $signed(b.right) &&
                   $signed(py) >= $signed(b.bottom) && $signed(py) <= $signed(b.top);
        endfunction

        function bit corner_in(edges_t a, edges_t b);
            return holds(b, a.left, a.top) || holds(b, a.right, a.top) ||
                   holds(b, a.right, a.bottom) || holds(b, a.left, a.bottom);
        endfunction

        function void note_rect(rect_t r);
            edges_t e;
            place_t p;
            int     lay;
            bit     found;
            bit     hit;
            e.left   = EDGE_W'(2 * int'(r.cx) - int'(r.w));
            e.right  = EDGE_W'(2 * int'(r.cx) + int'(r.w));
            e.bottom = EDGE_W'(2 * int'(r.cy) - int'(r.h));
            e.top    = EDGE_W'(2 * int'(r.cy) + int'(r.h));
            found = 1'b0;
            lay   = 0;
            for (int l = 0; l < int'(open_layers) && !found; l++)
            begin
                hit = 1'b0;
                for (int c = 0; c < int'(fill[l]) && !hit; c++)
                    hit = corner_in(e, stored[l][c]) || corner_in(stored[l][c], e);
                if (!hit)
                begin
                    found = 1'b1;
                    lay   = l;
                end
            end
            // every open layer clashes: open a fresh one if any are left
            if (!found && open_layers < DEF_MAX_LAYERS)
            begin
                lay       = open_layers;
                fill[lay] = 0;
                open_layers++;
                found     = 1'b1;
            end
            if (found && fill[lay] < DEF_MAX_COLUMNS)
            begin
                stored[lay][fill[lay]] = e;
                p.layer    = OUT_IDX_W'(lay);
                p.column   = OUT_IDX_W'(fill[lay]);
                p.overflow = 1'b0;
                fill[lay]++;
                n_placed++;
            end
            else
            begin
                p.layer    = '0;
                p.column   = '0;
                p.overflow = 1'b1;
                n_overflow++;
            end
            pending_places.push_back(p);
        endfunction

        function void check_place(logic [OUT_IDX_W-1:0] layer, logic [OUT_IDX_W-1:0] column,
                                  logic overflow);
            place_t p;
            n_checked++;
            if (pending_places.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: placement with none expected: layer %0d column %0d ovf %0b",
                             $time, layer, column, overflow);
                return;
            end
            p = pending_places.pop_front();
            if (layer !== p.layer)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: layer_index expected %0d, got %0d", $time, p.layer, layer);
            end
            if (column !== p.column)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: column_index expected %0d, got %0d", $time, p.column, column);
            end
            if (overflow !== p.overflow)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: overflow expected %0b, got %0b", $time, p.overflow, overflow);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rect_in_if  rect_in ();
    rect_out_if result ();

    rect_layer_assigner_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rect_in (rect_in),
        .result  (result)
    );

    layer_tracker board;
    rect_t        sent_log [$];
    int           base_x [4];
    int           base_y [4];
    bit           src_idle;
    bit           snk_idle;

    always #2 clk = ~clk;

    function automatic rect_t mk(int cx, int cy, int w, int h);
        rect_t r;
        r.cx = CENTER_W'(cx);
        r.cy = CENTER_W'(cy);
        r.w  = SIZE_W'(w);
        r.h  = SIZE_W'(h);
        return r;
    endfunction

    function automatic int box_size();
        return ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 511));
    endfunction

    function automatic rect_t draw_rect();
        int pick;
        int k;
        int wide;
        int thin;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, 3);
        if (pick < 35)
            return mk(base_x[k] + int'($urandom_range(0, 255)) - 128,
                      base_y[k] + int'($urandom_range(0, 255)) - 128, box_size(), box_size());
        if (pick < 55 && sent_log.size() > 0)
            return sent_log[$urandom_range(0, sent_log.size() - 1)];
        if (pick < 70)
        begin
            // plus-shaped pairs: overlap with no corner inside
            wide = $urandom_range(256, 2047);
            thin = $urandom_range(0, 31);
            if ($urandom_range(0, 1))
                return mk(base_x[k], base_y[k], wide, thin);
            return mk(base_x[k], base_y[k], thin, wide);
        end
        return mk($urandom, $urandom, $urandom, $urandom);
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken
    task automatic send_rect(rect_t r);
        int gap;
        gap = src_idle ? int'($urandom_range(0, 14)) : 0;
        if (gap > 0)
        begin
            rect_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rect_in.valid      <= 1'b1;
        rect_in.center_x   <= r.cx;
        rect_in.center_y   <= r.cy;
        rect_in.box_width  <= r.w;
        rect_in.box_height <= r.h;
        do @(posedge clk); while (!rect_in.ready);
        board.note_rect(r);
        sent_log.push_back(r);
    endtask

    task automatic drain_results();
        int stall;
        forever
        begin
            stall = snk_idle ? int'($urandom_range(0, 14)) : 0;
            if (board.n_checked == 40 || board.n_checked == 420)
                stall = LONG_HOLD;
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (!result.valid);
            board.check_place(result.layer_index, result.column_index, result.overflow);
        end
    endtask

    initial
    begin
        #8_000_000;
        $display("timeout: %0d placements still outstanding", board.pending_places.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        drain_results();
    end

    initial
    begin
        rect_t r;
        board = new;
        rst_n              <= 1'b0;
        rect_in.valid      <= 1'b0;
        rect_in.center_x   <= '0;
        rect_in.center_y   <= '0;
        rect_in.box_width  <= '0;
        rect_in.box_height <= '0;
        result.ready       <= 1'b0;
        src_idle = 1'b1;
        snk_idle = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            base_x[k] = int'($urandom_range(0, 60000)) - 30000;
            base_y[k] = int'($urandom_range(0, 60000)) - 30000;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // point on point stacks into a second layer
        send_rect(mk(0, 0, 0, 0));
        send_rect(mk(0, 0, 0, 0));
        send_rect(mk(-32768, -32768, 32767, 32767));
        send_rect(mk(32767, 32767, 32767, 32767));
        send_rect(mk(32767, -32768, 0, 32767));
        send_rect(mk(-32768, 32767, 32767, 0));
        // crossing boxes share a layer
        send_rect(mk(4000, 0, 3200, 16));
        send_rect(mk(4000, 0, 16, 3200));
        // shared edge, degenerate line inside, enclosing box
        send_rect(mk(8000, 0, 32, 32));
        send_rect(mk(8032, 0, 32, 32));
        send_rect(mk(8000, 0, 0, 8));
        send_rect(mk(8000, 0, 200, 200));
        send_rect(mk(21845, -21846, 10922, 21845));
        send_rect(mk(-21846, 21845, 21845, 10922));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
            begin
                src_idle = 1'($urandom_range(0, 1));
                snk_idle = 1'($urandom_range(0, 1));
            end
            r = draw_rect();
            send_rect(r);
            // identical burst: opens layers until they run out
            if (i % 100 == 50)
                repeat (8) send_rect(r);
        end
        rect_in.valid <= 1'b0;

        while (board.pending_places.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d rectangles sent: %0d placed over %0d layers, %0d refused for lack of room",
                 sent_log.size(), board.n_placed, board.open_layers, board.n_overflow);
        $display("%0d placements checked, %0d mismatches", board.n_checked, board.errors);
        if (board.errors == 0 && board.pending_places.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
